>>> rtl/core/aip_pkg.sv
// Shared types, constants and helpers for the ASCII integer parser.
// No dependencies; every other file of the block imports this package.
package aip_pkg;

    localparam int PosW  = 16;            // stop position width
    localparam int AccW  = 64;            // magnitude accumulator width
    localparam int RadW  = 6;             // radix register width
    localparam int ModeW = 2;             // result mode register width
    localparam int CharW = 8;             // character width
    localparam int ProdW = AccW + RadW;   // accumulator times radix plus digit
    localparam int AddrW = 3;             // APB address width
    localparam int DataW = 32;            // APB data width

    // register map (index taken from paddr[2])
    localparam logic REG_RADIX = 1'b0;
    localparam logic REG_MODE  = 1'b1;

    // result modes; the unused code behaves as unsigned
    localparam logic [ModeW-1:0] MODE_S32 = 2'd0;
    localparam logic [ModeW-1:0] MODE_S64 = 2'd1;
    localparam logic [ModeW-1:0] MODE_U64 = 2'd2;

    // radix values of interest
    localparam logic [RadW-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [RadW-1:0] RADIX_ONE   = 6'd1;
    localparam logic [RadW-1:0] RADIX_TWO   = 6'd2;
    localparam logic [RadW-1:0] RADIX_OCT   = 6'd8;
    localparam logic [RadW-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RadW-1:0] RADIX_HEX   = 6'd16;
    localparam logic [RadW-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RadW-1:0] RADIX_RESET = RADIX_DEC;

    // characters
    localparam logic [CharW-1:0] CH_SPACE = 8'h20;
    localparam logic [CharW-1:0] CH_TAB   = 8'h09;
    localparam logic [CharW-1:0] CH_LF    = 8'h0A;
    localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
    localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
    localparam logic [CharW-1:0] CH_NINE  = 8'h39;
    localparam logic [CharW-1:0] CH_LO_A  = 8'h61;
    localparam logic [CharW-1:0] CH_LO_X  = 8'h78;
    localparam logic [CharW-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CharW-1:0] CH_UP_A  = 8'h41;
    localparam logic [CharW-1:0] CH_UP_X  = 8'h58;
    localparam logic [CharW-1:0] CH_UP_Z  = 8'h5A;

    // snapshot of a finished parse, handed to the result formatter
    typedef struct packed {
        logic [AccW-1:0]  acc;
        logic             neg;
        logic             ovf;
        logic [PosW-1:0]  end_idx;
        logic [ModeW-1:0] mode;
    } t_snap;

    typedef struct packed {
        logic            ok;
        logic [RadW-1:0] val;
    } t_digit;

    // digit value of a character: 0-9, a-z, A-Z
    function automatic t_digit digit_of(input logic [CharW-1:0] c);
        t_digit d;
        logic [CharW-1:0] t;
        d.ok  = 1'b0;
        d.val = '0;
        t     = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.ok  = 1'b1;
            t     = c - CH_ZERO;
            d.val = t[RadW-1:0];
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d.ok  = 1'b1;
            t     = c - CH_LO_A + 8'd10;
            d.val = t[RadW-1:0];
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d.ok  = 1'b1;
            t     = c - CH_UP_A + 8'd10;
            d.val = t[RadW-1:0];
        end
        return d;
    endfunction

    // saturating position increment
    function automatic logic [PosW-1:0] pos_inc(input logic [PosW-1:0] p);
        return (&p) ? p : p + 1'b1;
    endfunction

endpackage

>>> rtl/core/aip_cfg_regs.sv
// APB register file for the parser: radix and result mode.
// Depends on aip_pkg.
module aip_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [aip_pkg::AddrW-1:0]  paddr,
    input  logic [aip_pkg::DataW-1:0]  pwdata,
    output logic [aip_pkg::DataW-1:0]  prdata,
    output logic                       pready,
    output logic [aip_pkg::RadW-1:0]   o_radix,
    output logic [aip_pkg::ModeW-1:0]  o_mode
);
    import aip_pkg::*;

    logic                 reg_idx;
    logic [RadW-1:0]      r_radix_q;
    logic [ModeW-1:0]     r_mode;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[2];

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix_q <= RADIX_RESET;
            r_mode    <= MODE_S32;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_RADIX: r_radix_q <= pwdata[RadW-1:0];
                REG_MODE:  r_mode    <= pwdata[ModeW-1:0];
                default:   ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_RADIX: prdata = DataW'(r_radix_q);
            REG_MODE:  prdata = DataW'(r_mode);
            default:   prdata = '0;
        endcase
    end

    assign o_radix = r_radix_q;
    assign o_mode  = r_mode;

endmodule

>>> rtl/core/aip_parse.sv
// Per-character parse state machine with multiply-accumulate and a
// snapshot register that holds each finished parse. Depends on aip_pkg.
module aip_parse (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,       // consume the held character
    input  logic [aip_pkg::CharW-1:0]  i_char,
    input  logic                       i_last,
    input  logic [aip_pkg::RadW-1:0]   i_radix,
    input  logic [aip_pkg::ModeW-1:0]  i_mode,
    input  logic                       i_snap_take,
    output logic                       o_snap_v,
    output aip_pkg::t_snap             o_snap
);
    import aip_pkg::*;

    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_SIGN   = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_PREFIX = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    logic [2:0]      r_phase, n_phase;
    logic            r_neg, n_neg;
    logic [RadW-1:0] r_ar, n_ar;
    logic [AccW-1:0] r_acc, n_acc;
    logic            r_ovf, n_ovf;
    logic [PosW-1:0] r_ci, n_ci;
    logic [PosW-1:0] r_end, n_end;
    logic            r_snap_v;
    t_snap           r_snap;

    t_digit          dg;
    logic            is_ws, is_sign, is_x, auto_or_hex, rad_bad;
    logic [RadW-1:0] fd_rad, b_sel, b_eff;
    logic            fd, take;
    logic [ProdW-1:0] prod;

    // character classes
    assign dg          = digit_of(i_char);
    assign is_ws       = (i_char == CH_SPACE) || (i_char == CH_TAB) || (i_char == CH_LF);
    assign is_sign     = (i_char == CH_PLUS) || (i_char == CH_MINUS);
    assign is_x        = (i_char == CH_LO_X) || (i_char == CH_UP_X);
    assign auto_or_hex = (i_radix == RADIX_AUTO) || (i_radix == RADIX_HEX);
    assign rad_bad     = (i_radix == RADIX_ONE) || (i_radix > RADIX_MAX);
    assign fd_rad      = (i_radix == RADIX_AUTO) ? RADIX_DEC : i_radix;

    // before the first digit the live radix applies, after it the latched one
    assign b_sel = ((r_phase == PH_SPACE) || (r_phase == PH_SIGN)) ? fd_rad : r_ar;

    // multiply-accumulate; the top bits give an exact overflow test
    assign b_eff = (b_sel < RADIX_TWO) ? RADIX_TWO : b_sel;
    assign prod  = ProdW'(r_acc) * ProdW'(b_eff) + ProdW'(dg.val);

    // next state for one character
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_ar    = r_ar;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        n_end   = r_end;
        n_ci    = pos_inc(r_ci);
        fd      = 1'b0;
        take    = 1'b0;

        unique case (r_phase)
            PH_SPACE: begin
                if (is_ws) begin
                end else if (is_sign) begin
                    n_neg   = (i_char == CH_MINUS);
                    n_phase = PH_SIGN;
                end else begin
                    fd = 1'b1;
                end
            end
            PH_SIGN: fd = 1'b1;
            PH_ZERO: begin
                if (is_x && auto_or_hex) begin
                    n_ar    = RADIX_HEX;
                    n_phase = PH_PREFIX;
                end else if (dg.ok && dg.val < r_ar) begin
                    take = 1'b1;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_PREFIX, PH_DIGITS: begin
                if (dg.ok && dg.val < r_ar) take = 1'b1;
                else                        n_phase = PH_DONE;
            end
            default: ;
        endcase

        // first digit decision: latch the working radix
        if (fd) begin
            if (rad_bad) begin
                n_phase = PH_DONE;
            end else if (i_char == CH_ZERO && auto_or_hex) begin
                n_ar    = (i_radix == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
                n_acc   = '0;
                n_end   = pos_inc(r_ci);
                n_phase = PH_ZERO;
            end else begin
                n_ar = fd_rad;
                if (dg.ok && dg.val < fd_rad) take = 1'b1;
                else                          n_phase = PH_DONE;
            end
        end

        // accumulate a digit, saturating on overflow
        if (take) begin
            if (!r_ovf) begin
                if (|prod[ProdW-1:AccW]) begin
                    n_ovf = 1'b1;
                    n_acc = '1;
                end else begin
                    n_acc = prod[AccW-1:0];
                end
            end
            n_end   = pos_inc(r_ci);
            n_phase = PH_DIGITS;
        end
    end

    // parse state; a last character hands off and restarts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_neg   <= 1'b0;
            r_ar    <= '0;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_ci    <= '0;
            r_end   <= '0;
        end else if (i_go) begin
            if (i_last) begin
                r_phase <= PH_SPACE;
                r_neg   <= 1'b0;
                r_ar    <= '0;
                r_acc   <= '0;
                r_ovf   <= 1'b0;
                r_ci    <= '0;
                r_end   <= '0;
            end else begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_ar    <= n_ar;
                r_acc   <= n_acc;
                r_ovf   <= n_ovf;
                r_ci    <= n_ci;
                r_end   <= n_end;
            end
        end
    end

    // snapshot stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_v <= 1'b0;
        end else if (i_go && i_last) begin
            r_snap_v <= 1'b1;
        end else if (i_snap_take) begin
            r_snap_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && i_last) begin
            r_snap.acc     <= n_acc;
            r_snap.neg     <= n_neg;
            r_snap.ovf     <= n_ovf;
            r_snap.end_idx <= n_end;
            r_snap.mode    <= i_mode;
        end
    end

    assign o_snap_v = r_snap_v;
    assign o_snap   = r_snap;

endmodule

>>> rtl/core/aip_clamp.sv
// Result formatter: signs, clamps or wraps the magnitude and holds the
// output word until taken. Depends on aip_pkg.
module aip_clamp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,      // load a snapshot
    input  aip_pkg::t_snap            i_snap,
    input  logic                      i_take,    // output word taken
    output logic                      o_valid,
    output logic [aip_pkg::AccW-1:0]  o_value,
    output logic [aip_pkg::PosW-1:0]  o_stop,
    output logic                      o_err
);
    import aip_pkg::*;

    localparam logic [AccW-1:0] S32_MIN_MAG = 64'h0000_0000_8000_0000;
    localparam logic [AccW-1:0] S32_MAX     = 64'h0000_0000_7FFF_FFFF;
    localparam logic [AccW-1:0] S32_MIN_SX  = 64'hFFFF_FFFF_8000_0000;
    localparam logic [AccW-1:0] S64_MIN_MAG = 64'h8000_0000_0000_0000;
    localparam logic [AccW-1:0] S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

    logic            r_valid;
    logic [AccW-1:0] r_value, n_value;
    logic [PosW-1:0] r_stop;
    logic            r_err, n_err;
    logic [31:0]     neg32;
    logic [AccW-1:0] v;

    assign v     = i_snap.acc;
    assign neg32 = 32'd0 - v[31:0];

    // clamp or wrap by mode
    always_comb begin
        n_value = v;
        n_err   = 1'b0;
        case (i_snap.mode)
            MODE_S32: begin
                if (i_snap.neg) begin
                    if (v > S32_MIN_MAG) begin
                        n_err   = 1'b1;
                        n_value = S32_MIN_SX;
                    end else begin
                        n_value = {{32{neg32[31]}}, neg32};
                    end
                end else if (v > S32_MAX) begin
                    n_err   = 1'b1;
                    n_value = S32_MAX;
                end
            end
            MODE_S64: begin
                if (i_snap.neg) begin
                    if (v > S64_MIN_MAG) begin
                        n_err   = 1'b1;
                        n_value = S64_MIN_MAG;
                    end else begin
                        n_value = '0 - v;
                    end
                end else if (v > S64_MAX) begin
                    n_err   = 1'b1;
                    n_value = S64_MAX;
                end
            end
            default: begin
                // unsigned; the spare code behaves the same
                if (i_snap.ovf) begin
                    n_err   = 1'b1;
                    n_value = '1;
                end else begin
                    n_value = i_snap.neg ? ('0 - v) : v;
                end
            end
        endcase
        if (i_snap.ovf) n_err = 1'b1;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_go) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_value <= n_value;
            r_stop  <= i_snap.end_idx;
            r_err   <= n_err;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_stop  = r_stop;
    assign o_err   = r_err;

endmodule

>>> rtl/core/ascii_integer_parser.sv
// Top level of the streaming ASCII integer parser: input register, parse
// stage, formatter and APB registers. Depends on aip_pkg and its submodules.
//
//  port group   dir  tdata / tuser fields (low bit first)          notes
//  s_ (input)   in   tdata: char_code[7:0]; tlast: is_last         one char per word
//  m_ (output)  out  tdata: value_bits[63:0], stop_position[79:64]  one word per string
//                    tuser: range_error
//  APB          in   radix @0x0, result_mode @0x4                   pready tied high
//
// One character per cycle is accepted, with no gaps between words, unless a held last
// character waits as described below. A result word's last character moves from the input
// register into the parse state and snapshot register, then into the formatter's output register.
// A held non-last character never blocks the input; a held last character waits only
// while the snapshot and output registers are both full and the output word is not
// taken, and the input stalls meanwhile. Reset is synchronous, active low.
module ascii_integer_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input stream
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [7:0]                 i_s_tdata,   // [7:0] char_code
    input  logic                       i_s_tlast,   // is_last
    // output stream
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [79:0]                o_m_tdata,   // [63:0] value_bits, [79:64] stop_position
    output logic                       o_m_tuser,   // [0] range_error
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [aip_pkg::AddrW-1:0]  paddr,
    input  logic [aip_pkg::DataW-1:0]  pwdata,
    output logic [aip_pkg::DataW-1:0]  prdata,
    output logic                       pready
);
    import aip_pkg::*;

    logic             r_in_v;
    logic [CharW-1:0] r_in_char;
    logic             r_in_last;
    logic             par_go, snap_v, snap_free, out_free, fmt_go;
    t_snap            snap;
    logic [RadW-1:0]  cfg_radix;
    logic [ModeW-1:0] cfg_mode;
    logic [AccW-1:0]  res_value;
    logic [PosW-1:0]  res_stop;
    logic             res_err;

    // stage handoff
    assign out_free   = !o_m_tvalid || i_m_tready;
    assign snap_free  = !snap_v || out_free;
    assign fmt_go     = snap_v && out_free;
    assign par_go     = r_in_v && (!r_in_last || snap_free);
    assign o_s_tready = !r_in_v || par_go;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_v <= 1'b1;
        end else if (par_go) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    aip_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_radix (cfg_radix),
        .o_mode  (cfg_mode)
    );

    aip_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (par_go),
        .i_char      (r_in_char),
        .i_last      (r_in_last),
        .i_radix     (cfg_radix),
        .i_mode      (cfg_mode),
        .i_snap_take (fmt_go),
        .o_snap_v    (snap_v),
        .o_snap      (snap)
    );

    aip_clamp u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (fmt_go),
        .i_snap  (snap),
        .i_take  (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_value (res_value),
        .o_stop  (res_stop),
        .o_err   (res_err)
    );

    assign o_m_tdata = {res_stop, res_value};
    assign o_m_tuser = res_err;

    // a new result word only ever follows a held snapshot
    a_out_from_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(snap_v))
        else $error("result word without a parse snapshot");

    // a consumed last character always produces a snapshot
    a_last_snaps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (par_go && r_in_last) |=> snap_v)
        else $error("last character lost before snapshot");

    // ordinary characters are never held back
    a_no_stall_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && !r_in_last) |-> o_s_tready)
        else $error("stall on a non-last character");

endmodule
